### hdl/b2cf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b2cf_pkg
// Shared types and constants for the binary64 to custom float converter.
// ----------------------------------------------------------------------------
package b2cf_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_EXP_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_FRAC_WIDTH = 2'd1;
   localparam logic [1:0] CSR_ROUND_MODE = 2'd2;

   // rounding modes
   localparam logic [1:0] RND_UP      = 2'd0;
   localparam logic [1:0] RND_TRUNC   = 2'd1;
   localparam logic [1:0] RND_NEAREST = 2'd2;

   // request classes decided in the first stage
   localparam logic [2:0] KIND_NUM  = 3'd0;
   localparam logic [2:0] KIND_PASS = 3'd1;
   localparam logic [2:0] KIND_NAN  = 3'd2;
   localparam logic [2:0] KIND_INF  = 3'd3;
   localparam logic [2:0] KIND_ZERO = 3'd4;
   localparam logic [2:0] KIND_OVF  = 3'd5;

   localparam int PIPE_DEPTH = 4;

   // decode stage result
   typedef struct packed {
      logic [63:0]        src;
      logic [2:0]         kind;
      logic [52:0]        sig;
      logic [5:0]         top;
      logic signed [12:0] te;
      logic signed [11:0] lsb;
   } s1_type;

   // shift amount stage result
   typedef struct packed {
      logic [63:0]        src;
      logic [2:0]         kind;
      logic [52:0]        sig;
      logic signed [12:0] te;
      logic [5:0]         shl;
      logic [5:0]         shr;
   } s2_type;

   // align and round stage result
   typedef struct packed {
      logic [63:0]        src;
      logic [2:0]         kind;
      logic signed [12:0] te;
      logic [52:0]        q;
      logic               inc;
   } s3_type;

endpackage : b2cf_pkg
`default_nettype wire

### hdl/binary64_to_custom_float.sv
`default_nettype none
// path: a request passes the decode, shift, align/round and pack registers before result valid
// throughput: one request per cycle while the result side does not stall, all stages advance together
// a stall on the result side holds every stage in place
// reset: synchronous, clears stage valid bits and restores the format
// registers to 8 exponent bits, 23 fraction bits, nearest-even rounding
// ----------------------------------------------------------------------------
// binary64_to_custom_float
// Converts binary64 patterns to a configurable narrow IEEE-style format with
// selectable rounding, through decode, shift, align/round and pack stages.
// ----------------------------------------------------------------------------
module binary64_to_custom_float (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // source_bits[63:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // packed_bits[63:0]
   input  wire logic        csr_wen,
   input  wire logic [1:0]  csr_index,
   input  wire logic [5:0]  csr_wdata
);
   import b2cf_pkg::*;

   logic [3:0] ew_ff;
   logic [5:0] fw_ff;
   logic [1:0] rm_ff;

   logic [PIPE_DEPTH-1:0] v_ff, v_in;
   logic en;

   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   logic [63:0] out_ff, out_in;

   // common values from the format registers
   logic signed [12:0] bias, emax;
   assign bias = (13'sd1 <<< (ew_ff - 4'd1)) - 13'sd1;
   assign emax = (13'sd1 <<< ew_ff) - 13'sd1;

   // pipeline advance
   assign en         = !v_ff[PIPE_DEPTH-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = v_ff[PIPE_DEPTH-1];
   assign rsp_tdata  = out_ff;
   assign v_in       = {v_ff[PIPE_DEPTH-2:0], req_tvalid};

   // format registers with saturation
   always_ff @(posedge clock) begin
      if (reset) begin
         ew_ff <= 4'd8;
         fw_ff <= 6'd23;
         rm_ff <= RND_NEAREST;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_EXP_WIDTH: begin
               ew_ff <= (csr_wdata[3:0] < 4'd2) ? 4'd2 :
                        (csr_wdata[3:0] > 4'd11) ? 4'd11 : csr_wdata[3:0];
            end
            CSR_FRAC_WIDTH: begin
               fw_ff <= (csr_wdata == 6'd0) ? 6'd1 :
                        (csr_wdata > 6'd52) ? 6'd52 : csr_wdata;
            end
            CSR_ROUND_MODE: begin
               rm_ff <= csr_wdata[1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // stage 1: classify, find leading one, unbiased and target exponent
   always_comb begin
      logic [10:0]        ex;
      logic [51:0]        fr;
      logic [5:0]         pos;
      logic signed [12:0] e;
      ex  = req_tdata[62:52];
      fr  = req_tdata[51:0];
      pos = 6'd0;
      for (int i = 0; i < 52; i++) begin
         if (fr[i]) pos = 6'(i);
      end
      s1_in.src = req_tdata;
      s1_in.sig = {(ex != 11'd0), fr};
      s1_in.top = (ex != 11'd0) ? 6'd52 : pos;
      s1_in.lsb = (ex != 11'd0) ? ($signed({1'b0, ex}) - 12'sd1075) : -12'sd1074;
      e = 13'(s1_in.lsb) + $signed({7'd0, s1_in.top});
      s1_in.te = e + bias;
      if (ew_ff == 4'd11 && fw_ff == 6'd52) s1_in.kind = KIND_PASS;
      else if (ex == 11'h7FF) s1_in.kind = (fr != 52'd0) ? KIND_NAN : KIND_INF;
      else if (ex == 11'd0 && fr == 52'd0) s1_in.kind = KIND_ZERO;
      else if (s1_in.te >= emax) s1_in.kind = KIND_OVF;
      else s1_in.kind = KIND_NUM;
   end

   // stage 2: distance from source lsb to target ulp
   always_comb begin
      logic signed [12:0] sh;
      if (s1_ff.te >= 13'sd1)
         sh = $signed({7'd0, s1_ff.top}) - $signed({7'd0, fw_ff});
      else
         sh = 13'sd1 - bias - $signed({7'd0, fw_ff}) - 13'(s1_ff.lsb);
      s2_in.src  = s1_ff.src;
      s2_in.kind = s1_ff.kind;
      s2_in.sig  = s1_ff.sig;
      s2_in.te   = s1_ff.te;
      if (sh <= 13'sd0) begin
         s2_in.shl = 6'(-sh);
         s2_in.shr = 6'd0;
      end else begin
         s2_in.shl = 6'd0;
         s2_in.shr = (sh > 13'sd60) ? 6'd60 : sh[5:0];
      end
   end

   // stage 3: align significand and decide the round increment
   always_comb begin
      logic [63:0] sig64;
      logic        guard, sticky;
      sig64       = {11'd0, s2_ff.sig};
      s3_in.src   = s2_ff.src;
      s3_in.kind  = s2_ff.kind;
      s3_in.te    = s2_ff.te;
      guard       = 1'b0;
      sticky      = 1'b0;
      if (s2_ff.shr == 6'd0) begin
         s3_in.q   = s2_ff.sig << s2_ff.shl;
         s3_in.inc = 1'b0;
      end else begin
         s3_in.q = 53'(sig64 >> s2_ff.shr);
         guard   = sig64[s2_ff.shr - 6'd1];
         sticky  = |(sig64 & ((64'd1 << (s2_ff.shr - 6'd1)) - 64'd1));
         case (rm_ff)
            RND_UP:    s3_in.inc = guard | sticky;
            RND_TRUNC: s3_in.inc = 1'b0;
            default:   s3_in.inc = guard & (sticky | s3_in.q[0]);
         endcase
      end
   end

   // stage 4: add exponent, saturate, pack
   always_comb begin
      logic [63:0] base, mag, inf, sgn;
      logic signed [12:0] tem1;
      tem1 = s3_ff.te - 13'sd1;
      base = (s3_ff.te >= 13'sd1) ? ({53'd0, tem1[10:0]} << fw_ff) : 64'd0;
      mag  = base + {11'd0, s3_ff.q} + {63'd0, s3_ff.inc};
      inf  = {51'd0, emax} << fw_ff;
      sgn  = {63'd0, s3_ff.src[63]} << (7'(ew_ff) + 7'(fw_ff));
      if (mag >= inf) mag = inf;
      case (s3_ff.kind)
         KIND_PASS: out_in = s3_ff.src;
         KIND_NAN:  out_in = inf | (64'd1 << (fw_ff - 6'd1));
         KIND_INF:  out_in = sgn | inf;
         KIND_OVF:  out_in = sgn | inf;
         KIND_ZERO: out_in = 64'd0;
         default:   out_in = sgn | mag;
      endcase
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         s3_ff  <= s3_in;
         out_ff <= out_in;
      end
   end

   // assertions
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("ready does not follow output stall");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      (v_ff[0] && en) |=> v_ff[1])
      else $error("request lost between stages");

   a_upper_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata >> (7'(ew_ff) + 7'(fw_ff) + 7'd1)) == 64'd0))
      else $error("bits above the target format are set");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (v_ff[PIPE_DEPTH-1] && !rsp_tready) |=>
         (v_ff[PIPE_DEPTH-2:0] == $past(v_ff[PIPE_DEPTH-2:0])))
      else $error("pipeline moved during a stall");

endmodule : binary64_to_custom_float
`default_nettype wire

### tb/binary64_to_custom_float_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// binary64_to_custom_float_tb
// Sends binary64 patterns through the converter under many target formats and
// rounding modes, predicts every packed result and checks them in order.
// ----------------------------------------------------------------------------

// holds the expected packed results and the current target format
class conv_scoreboard;
   bit [3:0]  exp_w;
   bit [5:0]  frac_w;
   bit [1:0]  rmode;
   bit [63:0] pending[$];
   int        errors;

   function new();
      exp_w = 8; frac_w = 23; rmode = b2cf_pkg::RND_NEAREST; errors = 0;
   endfunction

   // register write as the block sees it, with saturation
   function void set_reg(bit [1:0] idx, bit [5:0] val);
      bit [5:0] v;
      v = val;
      if (idx == b2cf_pkg::CSR_EXP_WIDTH) begin
         v = {2'b00, val[3:0]};
         if (v < 2) v = 2;
         if (v > 11) v = 11;
         exp_w = v[3:0];
      end else if (idx == b2cf_pkg::CSR_FRAC_WIDTH) begin
         if (v < 1) v = 1;
         if (v > 52) v = 52;
         frac_w = v;
      end else if (idx == b2cf_pkg::CSR_ROUND_MODE) begin
         rmode = val[1:0];
      end
   endfunction

   // narrow-format conversion of one binary64 pattern
   function bit [63:0] convert(bit [63:0] x);
      bit        s;
      int        ex, ew, fw, p, e, bias, te, ulp, sh, lsb;
      bit [63:0] fr, sig, emax, inf, sign, q, rem, half, mag;
      s = x[63]; ex = int'(x[62:52]); fr = {12'd0, x[51:0]};
      ew = int'(exp_w); fw = int'(frac_w);
      emax = (64'd1 << ew) - 1;
      inf = emax << fw;
      sign = {63'd0, s} << (ew + fw);
      if (ew == 11 && fw == 52) return x;
      if (ex == 2047) return (fr != 0) ? (inf | (64'd1 << (fw - 1))) : (sign | inf);
      if (ex == 0 && fr == 0) return 64'd0;
      sig = (ex != 0) ? (fr | 64'h0010_0000_0000_0000) : fr;
      lsb = (ex != 0) ? ex - 1075 : -1074;
      p = 0;
      while (p < 63 && (sig >> (p + 1)) != 0) p++;
      e = lsb + p;
      bias = (1 << (ew - 1)) - 1;
      te = e + bias;
      if (te >= int'(emax)) return sign | inf;
      ulp = (te >= 1) ? e - fw : 1 - bias - fw;
      sh = ulp - lsb;
      if (sh <= 0) begin
         q = sig << (-sh);
      end else begin
         if (sh > 60) sh = 60;
         q = sig >> sh;
         rem = sig & ((64'd1 << sh) - 1);
         half = 64'd1 << (sh - 1);
         if (rmode == b2cf_pkg::RND_UP) begin
            if (rem != 0) q++;
         end else if (rmode != b2cf_pkg::RND_TRUNC) begin
            if (rem > half || (rem == half && q[0])) q++;
         end
      end
      mag = (te >= 1) ? ((64'(te - 1) << fw) + q) : q;
      if (mag >= inf) mag = inf;
      return sign | mag;
   endfunction

   function void note_request(bit [63:0] x);
      pending.push_back(convert(x));
   endfunction

   function void check_result(bit [63:0] got);
      bit [63:0] want;
      if (pending.size() == 0) begin
         $display("%0t: unexpected result %h", $time, got);
         errors++;
         return;
      end
      want = pending.pop_front();
      if (want !== got) begin
         $display("%0t: packed_bits expected %h actual %h", $time, want, got);
         errors++;
      end
   endfunction
endclass

module binary64_to_custom_float_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [63:0] rsp_tdata;
   logic        csr_wen = 0;
   logic [1:0]  csr_index = '0;
   logic [5:0]  csr_wdata = '0;

   int send_idle = 0;
   int recv_idle = 0;
   conv_scoreboard sb = new();

   binary64_to_custom_float DUT (.*);

   initial forever #5 clock = ~clock;

   // receiver with random stalls
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // valid stays up after an accept so the next request can follow directly
   task automatic send_request(bit [63:0] x);
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= x;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(x);
   endtask

   // write enable stays up for back to back writes
   task automatic write_reg(bit [1:0] idx, bit [5:0] val);
      csr_wen <= 1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      sb.set_reg(idx, val);
   endtask

   // wait until every result is back, then let the pipeline settle
   task automatic drain();
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (b2cf_pkg::PIPE_DEPTH + 2) @(posedge clock);
   endtask

   task automatic set_format(bit [5:0] ew, bit [5:0] fw, bit [5:0] rm);
      drain();
      write_reg(b2cf_pkg::CSR_EXP_WIDTH, ew);
      write_reg(b2cf_pkg::CSR_FRAC_WIDTH, fw);
      write_reg(b2cf_pkg::CSR_ROUND_MODE, rm);
      csr_wen <= 0;
   endtask

   // random value biased toward the target's exponent range
   function automatic bit [63:0] rand_value();
      bit [63:0] v;
      int        k, bias, ex;
      v = {$urandom, $urandom};
      k = $urandom_range(9);
      bias = (1 << (sb.exp_w - 1)) - 1;
      if (k < 6) begin
         ex = 1023 + $urandom_range(2 * bias + 4) - bias - 2 - int'(sb.frac_w) * (k == 5);
         if (ex < 0) ex = 0;
         if (ex > 2046) ex = 2046;
         v[62:52] = 11'(ex);
         if (k == 4) v[51:0] = v[51:0] & ~(52'hF_FFFF_FFFF_FFFF >> sb.frac_w);
      end else if (k == 6) begin
         v[62:52] = 11'd0;
      end else if (k == 7) begin
         v[62:52] = 11'h7FF;
         if ($urandom_range(1)) v[51:0] = 52'd0;
      end
      return v;
   endfunction

   task automatic directed();
      bit [63:0] list[$];
      list = '{64'h0, 64'h8000_0000_0000_0000, 64'h7FF0_0000_0000_0000,
               64'hFFF0_0000_0000_0000, 64'h7FF8_0000_0000_0001,
               64'hFFFF_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0000,
               64'hBFF8_0000_0000_0000, 64'h7FEF_FFFF_FFFF_FFFF,
               64'h0000_0000_0000_0001, 64'h000F_FFFF_FFFF_FFFF,
               64'h3FF0_0000_1000_0000, 64'h3FF0_0000_3000_0000,
               64'h47EF_FFFF_F000_0000, 64'h380F_FFFF_F000_0000,
               64'h3690_0000_0000_0000, 64'h5555_5555_5555_5555,
               64'hAAAA_AAAA_AAAA_AAAA};
      foreach (list[i]) send_request(list[i]);
   endtask

   initial begin
      int cfg, n, mode;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // reset format first, then the full width format, then out of range writes
      directed();
      set_format(11, 52, 2);
      directed();
      set_format(0, 0, 3);
      directed();
      set_format(15, 63, 0);
      directed();
      set_format(2, 1, 1);
      directed();
      for (mode = 0; mode < 3; mode++) begin
         send_idle = (mode == 0) ? 10 : (mode == 1) ? 55 : 0;
         recv_idle = (mode == 0) ? 55 : (mode == 1) ? 10 : 0;
         for (cfg = 0; cfg < 8; cfg++) begin
            set_format(6'($urandom_range(15)), 6'($urandom_range(63)),
                       6'($urandom_range(3)));
            if (cfg == 0) set_format(11, 52, 6'($urandom_range(3)));
            if (cfg == 1) set_format(2, 1, 0);
            for (n = 0; n < 60; n++) send_request(rand_value());
         end
      end
      drain();
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("FAILURE");
      $finish;
   end
endmodule
`default_nettype wire

### sim.f
hdl/b2cf_pkg.sv
hdl/binary64_to_custom_float.sv
tb/binary64_to_custom_float_tb.sv
